>>> design/mrp_pd_attitude_torque_assert.svh
// Assertion macros used by the checker file mrppd_chk.sv.
`ifndef MRP_PD_ATTITUDE_TORQUE_ASSERT_SVH
`define MRP_PD_ATTITUDE_TORQUE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MRPPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRPPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mrppd_pkg.sv
`default_nettype none

package mrppd_pkg;

    localparam int AXES        = 3;
    localparam int NSTAGE      = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int INERTIA_W   = 21;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_K,
        REG_GAIN_P,
        REG_INERTIA_ROW0,
        REG_INERTIA_ROW1,
        REG_INERTIA_ROW2,
        REG_KNOWN_TORQUE_X,
        REG_KNOWN_TORQUE_Y,
        REG_KNOWN_TORQUE_Z
    } cfg_reg_t;

    typedef logic [1:0] axis_t;

    // Cyclic neighbours of each axis for the cross products.
    localparam axis_t AX_NEXT [AXES] = '{2'd1, 2'd2, 2'd0};
    localparam axis_t AX_PREV [AXES] = '{2'd2, 2'd0, 2'd1};

    typedef struct packed {
        logic signed [23:0] sigma_err_x;
        logic signed [23:0] sigma_err_y;
        logic signed [23:0] sigma_err_z;
        logic signed [23:0] rate_err_x;
        logic signed [23:0] rate_err_y;
        logic signed [23:0] rate_err_z;
        logic signed [23:0] ref_rate_x;
        logic signed [23:0] ref_rate_y;
        logic signed [23:0] ref_rate_z;
        logic signed [23:0] ref_accel_x;
        logic signed [23:0] ref_accel_y;
        logic signed [23:0] ref_accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
    } torque_t;

endpackage

`default_nettype wire

>>> design/mrp_pd_attitude_torque.sv
`default_nettype none
// Channel   Handshake                    Payload
// sample    sample_valid / sample_ready  sample (sigma, wBR, wRN, dwRN)
// torque    torque_valid / torque_ready  torque (Q16.16, saturated)
// config    cfg_wen                      cfg_index, cfg_data
//
// Six register stages; a sample transfer shows its torque after passing all six.
// One sample per cycle is taken while torque_ready does not stall the pipeline.
// Each stage loads when it is empty or the stage after it moves on, so a
// stall on torque_ready fills the bubbles and then holds sample_ready low.
// rst_n clears the stage valid bits and all configuration registers.

module mrp_pd_attitude_torque (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [mrppd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrppd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  mrppd_pkg::sample_t                  sample,
    output logic                                torque_valid,
    input  logic                                torque_ready,
    output mrppd_pkg::torque_t                  torque
);

    import mrppd_pkg::*;

    // configuration
    logic [23:0]                  gain_k_reg;
    logic [23:0]                  gain_p_reg;
    logic [CFG_DATA_W-1:0]        inertia_row_reg [AXES];
    logic signed [31:0]           known_torque_reg [AXES];
    logic signed [INERTIA_W-1:0]  inertia [AXES][AXES];

    // pipeline control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;

    // stage 1: inputs and body rate
    logic signed [23:0] s1_sig_reg [AXES];
    logic signed [23:0] s1_sig_next [AXES];
    logic signed [23:0] s1_wbr_reg [AXES];
    logic signed [23:0] s1_wbr_next [AXES];
    logic signed [23:0] s1_wrn_reg [AXES];
    logic signed [23:0] s1_wrn_next [AXES];
    logic signed [23:0] s1_dw_reg [AXES];
    logic signed [23:0] s1_dw_next [AXES];
    logic signed [24:0] s1_w_reg [AXES];
    logic signed [24:0] s1_w_next [AXES];

    // stage 2: first products
    logic signed [45:0] s2_hp_reg [AXES][AXES];
    logic signed [45:0] s2_hp_next [AXES][AXES];
    logic signed [48:0] s2_ca_reg [AXES];
    logic signed [48:0] s2_ca_next [AXES];
    logic signed [48:0] s2_cb_reg [AXES];
    logic signed [48:0] s2_cb_next [AXES];
    logic signed [48:0] s2_kp_reg [AXES];
    logic signed [48:0] s2_kp_next [AXES];
    logic signed [48:0] s2_pp_reg [AXES];
    logic signed [48:0] s2_pp_next [AXES];
    logic signed [23:0] s2_wrn_reg [AXES];
    logic signed [23:0] s2_dw_reg [AXES];

    // stage 3: momentum, corrected acceleration, feedback
    logic signed [48:0] h_acc [AXES];
    logic signed [50:0] wc_acc [AXES];
    logic signed [29:0] wc_rnd [AXES];
    logic signed [52:0] fb_acc [AXES];
    logic signed [35:0] s3_h_reg [AXES];
    logic signed [35:0] s3_h_next [AXES];
    logic signed [30:0] s3_a_reg [AXES];
    logic signed [30:0] s3_a_next [AXES];
    logic signed [33:0] s3_fb_reg [AXES];
    logic signed [33:0] s3_fb_next [AXES];
    logic signed [23:0] s3_wrn_reg [AXES];

    // stage 4: second products
    logic signed [59:0] s4_ga_reg [AXES];
    logic signed [59:0] s4_ga_next [AXES];
    logic signed [59:0] s4_gb_reg [AXES];
    logic signed [59:0] s4_gb_next [AXES];
    logic signed [51:0] s4_fp_reg [AXES][AXES];
    logic signed [51:0] s4_fp_next [AXES][AXES];
    logic signed [33:0] s4_fb_reg [AXES];

    // stage 5: gyroscopic and feed-forward terms
    logic signed [61:0] gyr_acc [AXES];
    logic signed [54:0] ff_acc [AXES];
    logic signed [40:0] s5_gyr_reg [AXES];
    logic signed [40:0] s5_gyr_next [AXES];
    logic signed [41:0] s5_ff_reg [AXES];
    logic signed [41:0] s5_ff_next [AXES];
    logic signed [33:0] s5_fb_reg [AXES];

    // stage 6: sum and saturate
    logic signed [43:0] t_sum [AXES];
    logic signed [31:0] t_sat [AXES];
    torque_t            torque_reg;
    torque_t            torque_next;

    // ------------------------------------------------------------------
    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_k_reg <= '0;
            gain_p_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                inertia_row_reg[i]  <= '0;
                known_torque_reg[i] <= '0;
            end
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_K:         gain_k_reg          <= cfg_data[23:0];
                REG_GAIN_P:         gain_p_reg          <= cfg_data[23:0];
                REG_INERTIA_ROW0:   inertia_row_reg[0]  <= cfg_data;
                REG_INERTIA_ROW1:   inertia_row_reg[1]  <= cfg_data;
                REG_INERTIA_ROW2:   inertia_row_reg[2]  <= cfg_data;
                REG_KNOWN_TORQUE_X: known_torque_reg[0] <= $signed(cfg_data[31:0]);
                REG_KNOWN_TORQUE_Y: known_torque_reg[1] <= $signed(cfg_data[31:0]);
                REG_KNOWN_TORQUE_Z: known_torque_reg[2] <= $signed(cfg_data[31:0]);
                default:            gain_k_reg          <= gain_k_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                inertia[r][c] = $signed(inertia_row_reg[r][INERTIA_W*c +: INERTIA_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage advance: a stage moves on when empty or when the next one does
    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || torque_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = sample_valid;
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign sample_ready = adv[0];
    assign torque_valid = valid_reg[NSTAGE-1];
    assign torque       = torque_reg;

    // ------------------------------------------------------------------
    // stage 1
    always_comb
    begin
        s1_sig_next[0] = sample.sigma_err_x;
        s1_sig_next[1] = sample.sigma_err_y;
        s1_sig_next[2] = sample.sigma_err_z;
        s1_wbr_next[0] = sample.rate_err_x;
        s1_wbr_next[1] = sample.rate_err_y;
        s1_wbr_next[2] = sample.rate_err_z;
        s1_wrn_next[0] = sample.ref_rate_x;
        s1_wrn_next[1] = sample.ref_rate_y;
        s1_wrn_next[2] = sample.ref_rate_z;
        s1_dw_next[0]  = sample.ref_accel_x;
        s1_dw_next[1]  = sample.ref_accel_y;
        s1_dw_next[2]  = sample.ref_accel_z;
        for (int i = 0; i < AXES; i++)
        begin
            s1_w_next[i] = 25'(s1_wbr_next[i]) + 25'(s1_wrn_next[i]);
        end
    end

    // stage 2: I*w terms, w x wRN terms, gain products
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                s2_hp_next[r][c] = inertia[r][c] * s1_w_reg[c];
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            s2_ca_next[i] = s1_w_reg[AX_NEXT[i]] * s1_wrn_reg[AX_PREV[i]];
            s2_cb_next[i] = s1_w_reg[AX_PREV[i]] * s1_wrn_reg[AX_NEXT[i]];
            s2_kp_next[i] = $signed({1'b0, gain_k_reg}) * s1_sig_reg[i];
            s2_pp_next[i] = $signed({1'b0, gain_p_reg}) * s1_wbr_reg[i];
        end
    end

    // stage 3: round half up by adding half an LSB before the arithmetic shift
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            h_acc[i] = 49'(s2_hp_reg[i][0]) + 49'(s2_hp_reg[i][1])
                     + 49'(s2_hp_reg[i][2]) + 49'sd2048;
            s3_h_next[i] = $signed(h_acc[i][47:12]);

            wc_acc[i] = 51'(s2_ca_reg[i]) - 51'(s2_cb_reg[i]) + 51'sd524288;
            wc_rnd[i] = $signed(wc_acc[i][49:20]);
            s3_a_next[i] = 31'(s2_dw_reg[i]) - 31'(wc_rnd[i]);

            fb_acc[i] = 53'sd131072 - 53'(s2_kp_reg[i]) - (53'(s2_pp_reg[i]) <<< 2);
            s3_fb_next[i] = $signed(fb_acc[i][51:18]);
        end
    end

    // stage 4: wRN x h terms, I*a terms
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            s4_ga_next[i] = s3_wrn_reg[AX_NEXT[i]] * s3_h_reg[AX_PREV[i]];
            s4_gb_next[i] = s3_wrn_reg[AX_PREV[i]] * s3_h_reg[AX_NEXT[i]];
        end
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                s4_fp_next[r][c] = inertia[r][c] * s3_a_reg[c];
            end
        end
    end

    // stage 5
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            gyr_acc[i] = 62'(s4_ga_reg[i]) - 62'(s4_gb_reg[i]) + 62'sd524288;
            s5_gyr_next[i] = $signed(gyr_acc[i][60:20]);

            ff_acc[i] = 55'(s4_fp_reg[i][0]) + 55'(s4_fp_reg[i][1])
                      + 55'(s4_fp_reg[i][2]) + 55'sd2048;
            s5_ff_next[i] = $signed(ff_acc[i][53:12]);
        end
    end

    // stage 6: clamp to the 32-bit limits
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            t_sum[i] = 44'(s5_fb_reg[i]) + 44'(s5_gyr_reg[i]) + 44'(s5_ff_reg[i])
                     - 44'(known_torque_reg[i]);
            if (t_sum[i] > 44'sd2147483647)
            begin
                t_sat[i] = 32'sh7FFFFFFF;
            end
            else if (t_sum[i] < -44'sd2147483648)
            begin
                t_sat[i] = 32'sh80000000;
            end
            else
            begin
                t_sat[i] = t_sum[i][31:0];
            end
        end
        torque_next.torque_x = t_sat[0];
        torque_next.torque_y = t_sat[1];
        torque_next.torque_z = t_sat[2];
    end

    // ------------------------------------------------------------------
    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_sig_reg <= s1_sig_next;
            s1_wbr_reg <= s1_wbr_next;
            s1_wrn_reg <= s1_wrn_next;
            s1_dw_reg  <= s1_dw_next;
            s1_w_reg   <= s1_w_next;
        end
        if (adv[1])
        begin
            s2_hp_reg  <= s2_hp_next;
            s2_ca_reg  <= s2_ca_next;
            s2_cb_reg  <= s2_cb_next;
            s2_kp_reg  <= s2_kp_next;
            s2_pp_reg  <= s2_pp_next;
            s2_wrn_reg <= s1_wrn_reg;
            s2_dw_reg  <= s1_dw_reg;
        end
        if (adv[2])
        begin
            s3_h_reg   <= s3_h_next;
            s3_a_reg   <= s3_a_next;
            s3_fb_reg  <= s3_fb_next;
            s3_wrn_reg <= s2_wrn_reg;
        end
        if (adv[3])
        begin
            s4_ga_reg <= s4_ga_next;
            s4_gb_reg <= s4_gb_next;
            s4_fp_reg <= s4_fp_next;
            s4_fb_reg <= s3_fb_reg;
        end
        if (adv[4])
        begin
            s5_gyr_reg <= s5_gyr_next;
            s5_ff_reg  <= s5_ff_next;
            s5_fb_reg  <= s4_fb_reg;
        end
        if (adv[5])
        begin
            torque_reg <= torque_next;
        end
    end

endmodule

`default_nettype wire

>>> design/mrppd_chk.sv
`default_nettype none
`include "mrp_pd_attitude_torque_assert.svh"

module mrppd_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               sample_ready,
    input  logic               torque_valid,
    input  logic               torque_ready,
    input  mrppd_pkg::torque_t torque
);

    // A free output side lets every stage advance, so the input must be ready to take a transfer.
    `MRPPD_ASSERT_SAME(a_ready_when_sink_free, clk, rst_n, (!torque_valid || torque_ready), sample_ready, "sample_ready low while output side free")

    // Nothing can be at the output when reset is first seen released.
    `MRPPD_ASSERT_SAME(a_empty_after_reset, clk, rst_n, $rose(rst_n), !torque_valid, "torque_valid high straight after reset")

    // Hold a stalled result.
    `MRPPD_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, (torque_valid && !torque_ready), (torque_valid && $stable(torque)), "stalled torque changed or dropped")

    // An idle input with an empty output leaves the input ready next cycle.
    `MRPPD_ASSERT_NEXT(a_ready_while_empty, clk, rst_n, (!torque_valid && !sample_valid), sample_ready, "sample_ready low after idle cycle")

endmodule

bind mrp_pd_attitude_torque mrppd_chk u_mrppd_chk (.*);

`default_nettype wire

>>> tb/sv/torque_law_checker.sv
module torque_law_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [mrppd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mrppd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              sample_valid,
    input  logic                              sample_ready,
    input  mrppd_pkg::sample_t                sample,
    input  logic                              torque_valid,
    input  logic                              torque_ready,
    input  mrppd_pkg::torque_t                torque,
    output int                                torque_errors,
    output int                                torques_pending,
    output int                                torques_checked,
    output int                                axes_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    import mrppd_pkg::*;

    localparam longint TORQUE_MAX = 64'sd2147483647;
    localparam longint TORQUE_MIN = -64'sd2147483648;
    localparam int     REPORT_MAX = 10;

    // Local copy of the control registers.
    logic [23:0]           prop_gain;
    logic [23:0]           rate_gain;
    logic [CFG_DATA_W-1:0] inertia_rows [AXES];
    longint                ext_torque [AXES];

    torque_t torque_due [$];
    string   axis_name [AXES] = '{"x", "y", "z"};

    // Round half up: add half an LSB of the result, then floor.
    function automatic longint rounded(input longint v, input int drop);
        return (v + (longint'(1) <<< (drop - 1))) >>> drop;
    endfunction

    function automatic torque_t control_torque(input sample_t s);
        longint sig [AXES];
        longint wbr [AXES];
        longint wrn [AXES];
        longint dw [AXES];
        longint w [AXES];
        longint h [AXES];
        longint gyro [AXES];
        longint acc_ref [AXES];
        longint ff [AXES];
        longint inert [AXES][AXES];
        longint acc;
        longint wc;
        longint sum;
        int n;
        int p;
        logic [31:0] axis_out [AXES];
        sig[0] = $signed(s.sigma_err_x);
        sig[1] = $signed(s.sigma_err_y);
        sig[2] = $signed(s.sigma_err_z);
        wbr[0] = $signed(s.rate_err_x);
        wbr[1] = $signed(s.rate_err_y);
        wbr[2] = $signed(s.rate_err_z);
        wrn[0] = $signed(s.ref_rate_x);
        wrn[1] = $signed(s.ref_rate_y);
        wrn[2] = $signed(s.ref_rate_z);
        dw[0]  = $signed(s.ref_accel_x);
        dw[1]  = $signed(s.ref_accel_y);
        dw[2]  = $signed(s.ref_accel_z);
        for (int r = 0; r < AXES; r++)
            for (int c = 0; c < AXES; c++)
                inert[r][c] = $signed(inertia_rows[r][INERTIA_W*c +: INERTIA_W]);
        for (int i = 0; i < AXES; i++)
            w[i] = wbr[i] + wrn[i];
        // Angular momentum I*w, Q.28 down to Q.16
        for (int r = 0; r < AXES; r++)
        begin
            acc = 0;
            for (int c = 0; c < AXES; c++)
                acc += inert[r][c] * w[c];
            h[r] = rounded(acc, 12);
        end
        for (int i = 0; i < AXES; i++)
        begin
            n = (i + 1) % AXES;
            p = (i + 2) % AXES;
            gyro[i] = wrn[n] * h[p] - wrn[p] * h[n];
            wc = w[n] * wrn[p] - w[p] * wrn[n];
            acc_ref[i] = dw[i] - rounded(wc, 20);
        end
        for (int r = 0; r < AXES; r++)
        begin
            acc = 0;
            for (int c = 0; c < AXES; c++)
                acc += inert[r][c] * acc_ref[c];
            ff[r] = rounded(acc, 12);
        end
        for (int i = 0; i < AXES; i++)
        begin
            // Rate gain term scaled by 4 to line both products up at 34 fraction bits
            sum = -(longint'(prop_gain) * sig[i]) - (longint'(rate_gain) * wbr[i]) * 4;
            sum = rounded(sum, 18) + rounded(gyro[i], 20) + ff[i] - ext_torque[i];
            if (sum > TORQUE_MAX || sum < TORQUE_MIN)
                axes_clipped++;
            if (sum > TORQUE_MAX)
                sum = TORQUE_MAX;
            if (sum < TORQUE_MIN)
                sum = TORQUE_MIN;
            axis_out[i] = sum[31:0];
        end
        return torque_t'({axis_out[0], axis_out[1], axis_out[2]});
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        torque_errors++;
        if (torque_errors <= REPORT_MAX)
            $display("%0t torque %s: expected %0d, got %0d",
                     $time, what, $signed(want_v), $signed(got_v));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        torque_t want;
        if (!rst_n)
        begin
            prop_gain = '0;
            rate_gain = '0;
            for (int i = 0; i < AXES; i++)
            begin
                inertia_rows[i] = '0;
                ext_torque[i]   = 0;
            end
            torque_due.delete();
            torque_errors   = 0;
            torques_pending = 0;
            torques_checked = 0;
            axes_clipped    = 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                torque_due.push_back(control_torque(sample));
            if (torque_valid && torque_ready)
            begin
                if (torque_due.size() == 0)
                    note_mismatch("x with no sample outstanding", '0, torque.torque_x);
                else
                begin
                    want = torque_due.pop_front();
                    torques_checked++;
                    for (int i = 0; i < AXES; i++)
                        if (want[32*(AXES-1-i) +: 32] !== torque[32*(AXES-1-i) +: 32])
                            note_mismatch(axis_name[i], want[32*(AXES-1-i) +: 32],
                                          torque[32*(AXES-1-i) +: 32]);
                end
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_GAIN_K:         prop_gain = cfg_data[23:0];
                    REG_GAIN_P:         rate_gain = cfg_data[23:0];
                    REG_INERTIA_ROW0:   inertia_rows[0] = cfg_data;
                    REG_INERTIA_ROW1:   inertia_rows[1] = cfg_data;
                    REG_INERTIA_ROW2:   inertia_rows[2] = cfg_data;
                    REG_KNOWN_TORQUE_X: ext_torque[0] = $signed(cfg_data[31:0]);
                    REG_KNOWN_TORQUE_Y: ext_torque[1] = $signed(cfg_data[31:0]);
                    REG_KNOWN_TORQUE_Z: ext_torque[2] = $signed(cfg_data[31:0]);
                    default:            ;
                endcase
            end
            torques_pending = torque_due.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrppd_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [23:0] F_ZERO = 24'h000000;
    localparam logic [23:0] F_MAX  = 24'h7FFFFF;
    localparam logic [23:0] F_MIN  = 24'h800000;
    localparam logic [23:0] F_ONES = 24'hFFFFFF;
    localparam logic [23:0] F_ONE  = 24'h000001;
    localparam logic [23:0] CORNERS [5] = '{F_ZERO, F_MAX, F_MIN, F_ONES, F_ONE};

    typedef enum int {SET_MILD, SET_RAW, SET_HIGH, SET_LOW} setting_t;
    typedef enum int {RX_OPEN, RX_HALF, RX_LIGHT, RX_HEAVY} ready_mode_t;

    localparam setting_t PHASE_PLAN [PHASES] =
        '{SET_MILD, SET_RAW, SET_HIGH, SET_MILD, SET_LOW, SET_RAW, SET_MILD, SET_MILD};

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wen      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = REG_GAIN_K;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    sample_t                sample       = '0;
    logic                   torque_valid;
    logic                   torque_ready = 1'b0;
    torque_t                torque;

    int torque_errors;
    int torques_pending;
    int torques_checked;
    int axes_clipped;

    int          settings_used  = 0;
    int unsigned burst_left     = 0;
    bit          gaps_on        = 1'b1;
    bit          long_hold      = 1'b0;
    bit          long_hold_done = 1'b0;

    mrp_pd_attitude_torque uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .torque_valid (torque_valid),
        .torque_ready (torque_ready),
        .torque       (torque)
    );

    torque_law_checker law_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .torque_valid    (torque_valid),
        .torque_ready    (torque_ready),
        .torque          (torque),
        .torque_errors   (torque_errors),
        .torques_pending (torques_pending),
        .torques_checked (torques_checked),
        .axes_clipped    (axes_clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t build_sample(input logic [23:0] f [12]);
        return sample_t'({f[0], f[1], f[2], f[3], f[4], f[5],
                          f[6], f[7], f[8], f[9], f[10], f[11]});
    endfunction

    function automatic logic [23:0] rand_field();
        logic [23:0] v;
        int unsigned pick;
        v = 24'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = $signed(v) >>> $urandom_range(1, 23);   // keep sign, shrink magnitude
        else if (pick == 4)
            v = CORNERS[$urandom_range(0, 4)];
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[CFG_DATA_W-1:0];
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(input setting_t kind);
        logic [CFG_DATA_W-1:0] kg;
        logic [CFG_DATA_W-1:0] pg;
        logic [CFG_DATA_W-1:0] rows [AXES];
        logic [CFG_DATA_W-1:0] lk [AXES];
        logic [INERTIA_W-1:0]  e;
        for (int r = 0; r < AXES; r++)
        begin
            rows[r] = '0;
            for (int c = 0; c < AXES; c++)
            begin
                case (kind)
                    SET_MILD: e = (r == c) ? INERTIA_W'($urandom_range(256, 262143))
                                           : INERTIA_W'($urandom_range(0, 2048)) - 21'd1024;
                    SET_HIGH: e = 21'h0FFFFF;
                    SET_LOW:  e = 21'h100000;
                    default:  e = INERTIA_W'($urandom);
                endcase
                rows[r][INERTIA_W*c +: INERTIA_W] = e;
            end
            case (kind)
                SET_MILD: lk[r] = CFG_DATA_W'(32'($urandom_range(0, 1 << 20)) - 32'h80000);
                SET_HIGH: lk[r] = 63'h7FFFFFFF;
                SET_LOW:  lk[r] = 63'h80000000;
                default:  lk[r] = rand_word();
            endcase
        end
        case (kind)
            SET_MILD:
            begin
                kg = CFG_DATA_W'($urandom_range(0, 24'h0FFFFF));
                pg = CFG_DATA_W'($urandom_range(0, 24'h0FFFFF));
            end
            SET_HIGH:
            begin
                kg = 63'hFFFFFF;
                pg = 63'hFFFFFF;
            end
            SET_LOW:
            begin
                kg = '0;
                pg = '0;
            end
            default:
            begin
                // Upper bits set on purpose: only the register width may count
                kg = rand_word();
                pg = rand_word();
                rows[0] = rand_word();
            end
        endcase
        write_reg(REG_GAIN_K, kg);
        write_reg(REG_GAIN_P, pg);
        write_reg(REG_INERTIA_ROW0, rows[0]);
        write_reg(REG_INERTIA_ROW1, rows[1]);
        write_reg(REG_INERTIA_ROW2, rows[2]);
        write_reg(REG_KNOWN_TORQUE_X, lk[0]);
        write_reg(REG_KNOWN_TORQUE_Y, lk[1]);
        write_reg(REG_KNOWN_TORQUE_Z, lk[2]);
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    // Offer one sample and hold it until the transfer; idle between bursts while gaps_on is set.
    task automatic push_sample(input sample_t s);
        int unsigned gap;
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every torque has come back.
    task automatic settle();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (torques_pending != 0);
        repeat (NSTAGE + 2) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [23:0] f [12];
        for (int j = 0; j < 5; j++)
        begin
            for (int i = 0; i < 12; i++)
                f[i] = CORNERS[j];
            push_sample(build_sample(f));
        end
        // One field group at a time: sigma, rate error, reference rate, reference accel
        for (int g = 0; g < 4; g++)
        begin
            for (int i = 0; i < 12; i++)
                f[i] = (i / 3 != g) ? F_ZERO : ((g % 2 != 0) ? F_MIN : F_MAX);
            push_sample(build_sample(f));
        end
        for (int i = 0; i < 12; i++)
            f[i] = (i % 2 != 0) ? F_MIN : F_MAX;
        push_sample(build_sample(f));
    endtask

    initial
    begin
        ready_mode_t mode;
        int unsigned left;
        mode = RX_OPEN;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !long_hold_done)
            begin
                // Hold off long enough for the pipeline to fill and stall the input
                long_hold_done = 1'b1;
                torque_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = ready_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 160);
                end
                left--;
                case (mode)
                    RX_OPEN:  torque_ready <= 1'b1;
                    RX_HALF:  torque_ready <= ($urandom_range(0, 1) == 0);
                    RX_LIGHT: torque_ready <= ($urandom_range(0, 7) != 0);
                    default:  torque_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped at the %0d-cycle limit, %0d torques outstanding",
                 CYCLE_LIMIT, torques_pending);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [23:0] f [12];
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at reset: no gains, no inertia, no known torque
        for (int i = 0; i < 12; i++)
            f[i] = F_MAX;
        push_sample(build_sample(f));
        settle();

        apply_setting(SET_MILD);
        run_directed();
        settle();
        apply_setting(SET_HIGH);
        run_directed();
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            apply_setting(PHASE_PLAN[ph]);
            gaps_on = (ph % 3) != 2;
            if (ph == 1)
                long_hold = 1'b1;
            n = RANDOM_ITEMS / PHASES + ((ph < RANDOM_ITEMS % PHASES) ? 1 : 0);
            repeat (n)
            begin
                for (int i = 0; i < 12; i++)
                    f[i] = rand_field();
                push_sample(build_sample(f));
            end
            settle();
        end

        repeat (4 * NSTAGE) @(posedge clk);
        $display("%0d torque transfers checked over %0d register settings",
                 torques_checked, settings_used);
        $display("%0d torque components clipped at the 32-bit limits, %0d field errors",
                 axes_clipped, torque_errors);
        if (torque_errors == 0 && torques_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/mrppd_pkg.sv
design/mrp_pd_attitude_torque.sv
design/mrppd_chk.sv
tb/sv/torque_law_checker.sv
tb/sv/testbench.sv
